### sv/leg_forward_kinematics_core_assert.svh
// Assertion macros used by leg_forward_kinematics_core.
`ifndef LEG_FORWARD_KINEMATICS_CORE_ASSERT_SVH
`define LEG_FORWARD_KINEMATICS_CORE_ASSERT_SVH
// Checks that a condition implies a consequence in the same cycle.
`define LFK_ASSERT_IMP(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("%m: check failed");
// Checks that a condition implies a consequence in the next cycle.
`define LFK_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("%m: check failed");
`endif

### sv/lfk_pkg.sv
`default_nettype none
package lfk_pkg;
    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
    localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    // 2^30 = 1000 * MRAD_INT + MRAD_REM, so only the remainder part needs a division.
    localparam logic [20:0] MRAD_INT = 21'd1073741;
    localparam logic [9:0] MRAD_REM = 10'd824;
    // ceil(2^27 / 125), exact for dividends below 2^20.
    localparam logic [20:0] RECIP_125 = 21'd1073742;

    typedef enum logic [1:0] {
        REG_PIVOT_H = 2'd0,
        REG_PIVOT_V = 2'd1,
        REG_THIGH   = 2'd2,
        REG_SHIN    = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [35:0] z;
        logic               flip;
    } rot_t;

    function automatic logic signed [35:0] atan_q30(input int i);
        logic signed [35:0] t;
        case (i)
            0: t = 36'sd843314857;
            1: t = 36'sd497837829;
            2: t = 36'sd263043837;
            3: t = 36'sd133525159;
            4: t = 36'sd67021687;
            5: t = 36'sd33543516;
            6: t = 36'sd16775851;
            7: t = 36'sd8388437;
            8: t = 36'sd4194283;
            9: t = 36'sd2097149;
            10: t = 36'sd1048576;
            11: t = 36'sd524288;
            12: t = 36'sd262144;
            13: t = 36'sd131072;
            14: t = 36'sd65536;
            15: t = 36'sd32768;
            16: t = 36'sd16384;
            17: t = 36'sd8192;
            18: t = 36'sd4096;
            19: t = 36'sd2048;
            20: t = 36'sd1024;
            21: t = 36'sd512;
            22: t = 36'sd256;
            default: t = 36'sd128;
        endcase
        return t;
    endfunction

    // Round half away from zero of v / 2^s for s >= 1.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                        input int s);
        logic [63:0] m;
        logic [63:0] h;
        h = 64'd1 << (s - 1);
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + h) >> s;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767)
            r = 16'sh7fff;
        else if (v < -64'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction
endpackage
`default_nettype wire

### sv/lfk_prep.sv
`default_nettype none
// Converts one angle in milliradians to a reduced Q30 angle and the CORDIC seed.
module lfk_prep
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [13:0] mrad,
    output lfk_pkg::rot_t           seed
);
    logic [13:0] mag;
    logic [34:0] int_part;
    logic [22:0] rem_sum;
    logic [40:0] quo_prod;
    logic [35:0] q_abs;
    logic signed [35:0] q;
    logic signed [35:0] zr;
    lfk_pkg::rot_t seed_reg;
    lfk_pkg::rot_t seed_next;
    logic signed [35:0] q_reg;

    // Stage one: exact rounded scaling. The remainder term is divided by 1000
    // as a shift by 3 and a reciprocal multiply for the division by 125.
    assign mag = mrad[13] ? 14'(-mrad) : mrad;
    assign int_part = 35'(mag) * 35'(lfk_pkg::MRAD_INT);
    assign rem_sum = 23'(mag) * 23'(lfk_pkg::MRAD_REM) + 23'd500;
    assign quo_prod = 41'(rem_sum[22:3]) * 41'(lfk_pkg::RECIP_125);
    assign q_abs = 36'(int_part) + 36'(quo_prod[40:27]);
    assign q = mrad[13] ? -$signed(q_abs) : $signed(q_abs);

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q;
    end

    // Stage two: at most one wrap by 2*pi, then fold into the right half plane.
    always_comb
    begin
        zr = q_reg;
        if (zr > lfk_pkg::PI_Q30)
            zr = zr - lfk_pkg::TWO_PI_Q30;
        else if (zr < -lfk_pkg::PI_Q30)
            zr = zr + lfk_pkg::TWO_PI_Q30;
        seed_next.x = lfk_pkg::GAIN_Q30;
        seed_next.y = '0;
        seed_next.flip = 1'b0;
        seed_next.z = zr;
        if (zr > lfk_pkg::HALF_PI_Q30)
        begin
            seed_next.z = zr - lfk_pkg::PI_Q30;
            seed_next.flip = 1'b1;
        end
        else if (zr < -lfk_pkg::HALF_PI_Q30)
        begin
            seed_next.z = zr + lfk_pkg::PI_Q30;
            seed_next.flip = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            seed_reg <= seed_next;
    end

    assign seed = seed_reg;
endmodule
`default_nettype wire

### sv/lfk_cell.sv
`default_nettype none
// One CORDIC rotation stage for three angles, with the item payload beside it.
module lfk_cell
#(
    parameter int STAGE = 0,
    parameter int SIDE_W = 1
)
(
    input  wire logic              clk,
    input  wire logic              en,
    input  lfk_pkg::rot_t          a_in [3],
    input  wire logic [SIDE_W-1:0] side_in,
    output lfk_pkg::rot_t          a_out [3],
    output logic      [SIDE_W-1:0] side_out
);
    lfk_pkg::rot_t a_reg [3];
    lfk_pkg::rot_t a_next [3];
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            a_next[k] = a_in[k];
            if (!a_in[k].z[35])
            begin
                a_next[k].x = a_in[k].x - (a_in[k].y >>> STAGE);
                a_next[k].y = a_in[k].y + (a_in[k].x >>> STAGE);
                a_next[k].z = a_in[k].z - lfk_pkg::atan_q30(STAGE);
            end
            else
            begin
                a_next[k].x = a_in[k].x + (a_in[k].y >>> STAGE);
                a_next[k].y = a_in[k].y - (a_in[k].x >>> STAGE);
                a_next[k].z = a_in[k].z + lfk_pkg::atan_q30(STAGE);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            side_reg <= side_in;
        end
    end

    assign a_out = a_reg;
    assign side_out = side_reg;
endmodule
`default_nettype wire

### sv/leg_forward_kinematics_core.sv
// An accepted request passes the prep registers, the CORDIC cells, the post-processing
// registers and the output register before its result is valid.
// Throughput: one request per cycle; the chain of CORDIC cells moves every cycle
// that the output is free or taken, and stalls as a whole otherwise.
// Reset: rst_n clears the valid bits and returns the four registers to their
// reset values (4287, 2060, 6300, 8000); no clearing pass is needed.
`default_nettype none
`include "leg_forward_kinematics_core_assert.svh"
module leg_forward_kinematics_core
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [12:0] swing_angle,
    input  wire logic signed [12:0] lift_angle,
    input  wire logic signed [12:0] curl_angle,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      toe_x,
    output logic signed [15:0]      toe_y,
    output logic signed [15:0]      toe_z
);
    localparam int N = (CORDIC_STAGES < lfk_pkg::ATAN_ENTRIES) ?
                       CORDIC_STAGES : lfk_pkg::ATAN_ENTRIES;
    // Stages: two prep, N cells, three post-processing; plus output register.
    localparam int DEPTH = N + 6;

    logic signed [15:0] pivot_h_reg;
    logic signed [15:0] pivot_v_reg;
    logic [14:0] thigh_reg;
    logic [14:0] shin_reg;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_h_reg <= 16'sd4287;
            pivot_v_reg <= 16'sd2060;
            thigh_reg <= 15'd6300;
            shin_reg <= 15'd8000;
        end
        else if (cfg_we)
        begin
            case (lfk_pkg::reg_index_t'(cfg_index))
                lfk_pkg::REG_PIVOT_H: pivot_h_reg <= cfg_data;
                lfk_pkg::REG_PIVOT_V: pivot_v_reg <= cfg_data;
                lfk_pkg::REG_THIGH: thigh_reg <= cfg_data[14:0];
                lfk_pkg::REG_SHIN: shin_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // The whole pipe advances unless a finished result is waiting.
    assign adv = !out_valid || out_ready;
    assign in_ready = adv;
    assign out_valid = vld_reg[DEPTH-1];

    always_comb
    begin
        vld_next = {vld_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // Range reduction for the three angles.
    logic signed [13:0] ang [3];
    lfk_pkg::rot_t chain [N+1][3];
    assign ang[0] = 14'(lift_angle);
    assign ang[1] = 14'(lift_angle) + 14'(curl_angle);
    assign ang[2] = 14'(swing_angle);

    for (genvar k = 0; k < 3; k++)
    begin : g_prep
        lfk_prep u_prep
        (
            .clk(clk),
            .en(adv),
            .mrad(ang[k]),
            .seed(chain[0][k])
        );
    end

    logic [0:0] side [N+1];
    assign side[0] = 1'b0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        lfk_cell #(.STAGE(i), .SIDE_W(1)) u_cell
        (
            .clk(clk),
            .en(adv),
            .a_in(chain[i]),
            .side_in(side[i]),
            .a_out(chain[i+1]),
            .side_out(side[i+1])
        );
    end

    // Post stage one: apply the fold sign and scale by the link lengths.
    logic signed [33:0] c_l, s_l, c_b, s_b;
    logic signed [33:0] cs_reg, ss_reg;
    logic signed [49:0] tc_reg, ts_reg, bc_reg, bs_reg;
    assign c_l = chain[N][0].flip ? -chain[N][0].x : chain[N][0].x;
    assign s_l = chain[N][0].flip ? -chain[N][0].y : chain[N][0].y;
    assign c_b = chain[N][1].flip ? -chain[N][1].x : chain[N][1].x;
    assign s_b = chain[N][1].flip ? -chain[N][1].y : chain[N][1].y;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tc_reg <= 50'($signed({1'b0, thigh_reg})) * 50'(c_l);
            ts_reg <= 50'($signed({1'b0, thigh_reg})) * 50'(s_l);
            bc_reg <= 50'($signed({1'b0, shin_reg})) * 50'(c_b);
            bs_reg <= 50'($signed({1'b0, shin_reg})) * 50'(s_b);
            cs_reg <= chain[N][2].flip ? -chain[N][2].x : chain[N][2].x;
            ss_reg <= chain[N][2].flip ? -chain[N][2].y : chain[N][2].y;
        end
    end

    // Post stage two: sums with the pivots, rounding of r to Q14 and of z to a saturated integer.
    // Both r in Q14 and the swing cosine and sine fit in 32 signed bits.
    logic signed [51:0] r_sum, v_sum;
    logic signed [31:0] r14_reg;
    logic signed [15:0] z_reg, z2_reg;
    logic signed [31:0] cs2_reg, ss2_reg;
    assign r_sum = 52'(pivot_h_reg) * 52'sd1073741824 + 52'(tc_reg) + 52'(bc_reg);
    assign v_sum = 52'(pivot_v_reg) * 52'sd1073741824 + 52'(ts_reg) + 52'(bs_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r14_reg <= 32'(lfk_pkg::round_shift(64'(r_sum), 16));
            z_reg <= lfk_pkg::sat16(lfk_pkg::round_shift(64'(v_sum), 30));
            cs2_reg <= cs_reg[31:0];
            ss2_reg <= ss_reg[31:0];
        end
    end

    // Post stage three: swing rotation products.
    logic signed [63:0] px_reg, py_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= 64'(r14_reg) * 64'(cs2_reg);
            py_reg <= 64'(r14_reg) * 64'(ss2_reg);
            z2_reg <= z_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            toe_x <= lfk_pkg::sat16(lfk_pkg::round_shift(px_reg, 44));
            toe_y <= lfk_pkg::sat16(lfk_pkg::round_shift(py_reg, 44));
            toe_z <= z2_reg;
        end
    end

    `LFK_ASSERT_IMP(a_ready_free, clk, rst_n, !out_valid, in_ready)
    `LFK_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(toe_x))
    `LFK_ASSERT_NEXT(a_flow, clk, rst_n, adv && vld_reg[DEPTH-2], out_valid)
endmodule
`default_nettype wire
